FILE: rtl/tiled_mosaic_color_xor_defines.svh
// Assertion macros shared by the mosaic color XOR block.
// No dependencies; the including module must have clk and rst in scope.
`ifndef TILED_MOSAIC_COLOR_XOR_DEFINES_SVH
`define TILED_MOSAIC_COLOR_XOR_DEFINES_SVH

`define TMCX_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tiled_mosaic_color_xor: assertion failed");

`define TMCX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tiled_mosaic_color_xor: assertion failed");

`endif

FILE: rtl/tmcx_pkg.sv
// Types, constants and the tile color table of the mosaic color XOR block.
// No dependencies.
package tmcx_pkg;

  localparam int PIXEL_BITS = 32;
  localparam int CFG_DATA_BITS = 9;
  localparam int CFG_INDEX_BITS = 2;
  localparam int TILE_BITS = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int SIZE_RESET = 256;
  localparam int DEFAULT_MAX_WIDTH = 256;
  localparam int DEFAULT_MAX_HEIGHT = 256;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic                  wbank;
    logic [TILE_BITS-1:0]  tile;
    logic                  last;
    logic [PIXEL_BITS-1:0] pixel;
  } cmd_info_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  last;
  } result_t;

  function automatic logic [PIXEL_BITS-1:0] tile_colour(logic [TILE_BITS-1:0] idx);
    logic [PIXEL_BITS-1:0] c;
    unique case (idx)
      4'd0: c = 32'h0000_0080;
      4'd1: c = 32'h0000_8000;
      4'd2: c = 32'h0080_0000;
      4'd3: c = 32'h0000_e000;
      4'd4: c = 32'h0080_8000;
      4'd5: c = 32'h0080_0080;
      4'd6: c = 32'h0080_8080;
      4'd7: c = 32'h0000_8080;
      4'd8: c = 32'h00e0_e000;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/tmcx_fifo.sv
// Small register queue used between the front and back ends and at the output.
// Depends on nothing; depth must be a power of two.
module tmcx_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_BITS = $clog2(DEPTH);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS-1:0] wr_ptr;
  logic                do_push;
  logic                do_pop;

  assign empty = (count == '0);
  assign full = (count == ($clog2(DEPTH+1))'(DEPTH));
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_BITS'(1);
      if (do_pop) rd_ptr <= rd_ptr + PTR_BITS'(1);
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

FILE: rtl/tmcx_front.sv
// Front end: frame size registers, raster and mosaic position counters, bank choice.
// Depends on tmcx_pkg and tiled_mosaic_color_xor_defines.svh.
`include "tiled_mosaic_color_xor_defines.svh"

module tmcx_front #(
  parameter int MAX_WIDTH = tmcx_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = tmcx_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic [tmcx_pkg::PIXEL_BITS-1:0]       pixel_in,
  input  logic                                  cfg_write,
  input  logic [tmcx_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [tmcx_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] rd_addr,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] wr_addr,
  output tmcx_pkg::cmd_info_t                   info
);

  localparam int ADDR_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int WSIZE = $clog2(MAX_WIDTH + 1);
  localparam int HSIZE = $clog2(MAX_HEIGHT + 1);
  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT);
  localparam int TW = ((WSIZE > HSIZE) ? WSIZE : HSIZE) + 1;
  localparam int RESET_W = (tmcx_pkg::SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                             : tmcx_pkg::SIZE_RESET;
  localparam int RESET_H = (tmcx_pkg::SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                              : tmcx_pkg::SIZE_RESET;

  logic [WSIZE-1:0]     width;
  logic [HSIZE-1:0]     height;
  logic                 bank_select;
  logic [COL_BITS-1:0]  column_count;
  logic [ROW_BITS-1:0]  row_count;
  logic [ADDR_BITS-1:0] write_address;
  logic [COL_BITS-1:0]  source_column;
  logic [ROW_BITS-1:0]  source_row;
  logic [1:0]           tile_column;
  logic [1:0]           tile_row;

  logic                 last_col;
  logic                 last_row;
  logic                 frame_end;
  logic                 size_write;
  logic [TW+1:0]        col_step;
  logic [TW+1:0]        row_step;

  function automatic int clamp_size(logic [tmcx_pkg::CFG_DATA_BITS-1:0] v, int maxv);
    int r;
    r = int'(v);
    if (r == 0) r = 1;
    else if (r > maxv) r = maxv;
    return r;
  endfunction

  // Steps a running remainder of 3*i by n, carrying the quotient modulo four.
  function automatic logic [TW+1:0] advance(logic [TW-1:0] rem_in, logic [1:0] q_in,
                                            logic [TW-1:0] n);
    logic [TW-1:0] r;
    logic [1:0]    q;
    r = rem_in + TW'(3);
    q = q_in;
    for (int k = 0; k < 3; k++) begin
      if (r >= n) begin
        r = r - n;
        q = q + 2'd1;
      end
    end
    return {q, r};
  endfunction

  assign last_col = WSIZE'(column_count) >= (width - WSIZE'(1));
  assign last_row = HSIZE'(row_count) >= (height - HSIZE'(1));
  assign frame_end = last_col && last_row;
  assign size_write = cfg_write && ((cfg_index == tmcx_pkg::CFG_FRAME_WIDTH) ||
                                    (cfg_index == tmcx_pkg::CFG_FRAME_HEIGHT));

  always_comb begin
    col_step = advance(TW'(source_column), tile_column, TW'(width));
    row_step = advance(TW'(source_row), tile_row, TW'(height));
  end

  assign rd_addr = (ADDR_BITS'(source_row) * ADDR_BITS'(width)) + ADDR_BITS'(source_column);
  assign wr_addr = write_address;
  assign info.wbank = bank_select;
  assign info.tile = tmcx_pkg::TILE_BITS'(tile_row * 3 + tile_column);
  assign info.last = frame_end;
  assign info.pixel = pixel_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      width <= WSIZE'(RESET_W);
      height <= HSIZE'(RESET_H);
      bank_select <= 1'b0;
      column_count <= '0;
      row_count <= '0;
      write_address <= '0;
      source_column <= '0;
      source_row <= '0;
      tile_column <= '0;
      tile_row <= '0;
    end else begin
      if (accept && frame_end) bank_select <= ~bank_select;
      if (size_write) begin
        if (cfg_index == tmcx_pkg::CFG_FRAME_WIDTH) begin
          width <= WSIZE'(clamp_size(cfg_data, MAX_WIDTH));
        end else begin
          height <= HSIZE'(clamp_size(cfg_data, MAX_HEIGHT));
        end
        column_count <= '0;
        row_count <= '0;
        write_address <= '0;
        source_column <= '0;
        source_row <= '0;
        tile_column <= '0;
        tile_row <= '0;
      end else if (accept) begin
        if (frame_end) begin
          column_count <= '0;
          row_count <= '0;
          write_address <= '0;
          source_column <= '0;
          source_row <= '0;
          tile_column <= '0;
          tile_row <= '0;
        end else if (last_col) begin
          column_count <= '0;
          source_column <= '0;
          tile_column <= '0;
          row_count <= row_count + ROW_BITS'(1);
          write_address <= write_address + ADDR_BITS'(1);
          source_row <= ROW_BITS'(row_step[TW-1:0]);
          tile_row <= row_step[TW+1:TW];
        end else begin
          column_count <= column_count + COL_BITS'(1);
          write_address <= write_address + ADDR_BITS'(1);
          source_column <= COL_BITS'(col_step[TW-1:0]);
          tile_column <= col_step[TW+1:TW];
        end
      end
    end
  end

  `TMCX_ASSERT_NEXT(bank_swaps_a, accept && frame_end, bank_select != $past(bank_select))
  `TMCX_ASSERT(col_in_range_a, 1'b1, WSIZE'(column_count) < width)

endmodule

FILE: rtl/tmcx_back.sv
// Back end: two-bank frame store with clearing pass, tile color XOR, result queue.
// Depends on tmcx_pkg, tmcx_fifo and tiled_mosaic_color_xor_defines.svh.
`include "tiled_mosaic_color_xor_defines.svh"

module tmcx_back #(
  parameter int MAX_WIDTH = tmcx_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = tmcx_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cmd_valid,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] cmd_rd_addr,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] cmd_wr_addr,
  input  tmcx_pkg::cmd_info_t                     cmd_info,
  output logic                                    cmd_pop,
  output logic                                    clearing,
  input  logic                                    pop,
  output logic                                    empty,
  output tmcx_pkg::result_t                       result
);

  localparam int BANK_WORDS = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_BITS = $clog2(BANK_WORDS);
  localparam int CNT_BITS = $clog2(tmcx_pkg::QUEUE_DEPTH + 1);
  localparam logic [ADDR_BITS-1:0] LAST_CLEAR = ADDR_BITS'(BANK_WORDS - 1);

  logic [tmcx_pkg::PIXEL_BITS-1:0] bank0_mem [BANK_WORDS];
  logic [tmcx_pkg::PIXEL_BITS-1:0] bank1_mem [BANK_WORDS];
  logic [tmcx_pkg::PIXEL_BITS-1:0] bank0_rdata;
  logic [tmcx_pkg::PIXEL_BITS-1:0] bank1_rdata;

  logic [ADDR_BITS-1:0]            clear_addr;
  logic                            s1_valid;
  logic                            s1_bank;
  logic                            s1_last;
  logic [tmcx_pkg::PIXEL_BITS-1:0] s1_colour;

  logic [ADDR_BITS-1:0]            mem_waddr;
  logic [tmcx_pkg::PIXEL_BITS-1:0] mem_wdata;
  logic                            bank0_we;
  logic                            bank1_we;
  logic                            issue;
  logic [CNT_BITS-1:0]             out_count;
  logic                            out_full;
  tmcx_pkg::result_t               s1_result;

  assign issue = cmd_valid && !clearing &&
                 ((int'(out_count) + int'(s1_valid)) < tmcx_pkg::QUEUE_DEPTH);
  assign cmd_pop = issue;

  assign mem_waddr = clearing ? clear_addr : cmd_wr_addr;
  assign mem_wdata = clearing ? '0 : cmd_info.pixel;
  assign bank0_we = clearing || (issue && !cmd_info.wbank);
  assign bank1_we = clearing || (issue && cmd_info.wbank);

  always_ff @(posedge clk) begin
    if (bank0_we) bank0_mem[mem_waddr] <= mem_wdata;
    bank0_rdata <= bank0_mem[cmd_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (bank1_we) bank1_mem[mem_waddr] <= mem_wdata;
    bank1_rdata <= bank1_mem[cmd_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clear_addr <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (clearing) begin
        clear_addr <= clear_addr + ADDR_BITS'(1);
        if (clear_addr == LAST_CLEAR) clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_bank <= ~cmd_info.wbank;
      s1_last <= cmd_info.last;
      s1_colour <= tmcx_pkg::tile_colour(cmd_info.tile);
    end
  end

  assign s1_result.pixel = (s1_bank ? bank1_rdata : bank0_rdata) ^ s1_colour;
  assign s1_result.last = s1_last;

  tmcx_fifo #(
    .WIDTH($bits(tmcx_pkg::result_t)),
    .DEPTH(tmcx_pkg::QUEUE_DEPTH)
  ) u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (s1_valid),
    .push_data(s1_result),
    .pop      (pop),
    .pop_data (result),
    .empty    (empty),
    .full     (out_full),
    .count    (out_count)
  );

  `TMCX_ASSERT(result_room_a, s1_valid, !out_full)
  `TMCX_ASSERT(clear_idle_a, clearing, !cmd_valid && !s1_valid)
  `TMCX_ASSERT(clear_done_a, $fell(clearing), $past(clear_addr) == LAST_CLEAR)

endmodule

FILE: rtl/tiled_mosaic_color_xor.sv
// Mosaic color XOR over a double frame store: one result per accepted pixel.
// Path: an accepted pixel passes the command queue, the registered store read and the result queue.
// Throughput: one pixel per cycle while full is low; each pixel takes one read and one write of the store.
// Reset: counters and queues clear at once, then a clearing pass zeroes the store,
// one word of each bank per cycle over all MAX_WIDTH*MAX_HEIGHT words, with full held high.
module tiled_mosaic_color_xor #(
  parameter int MAX_WIDTH = tmcx_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = tmcx_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [tmcx_pkg::PIXEL_BITS-1:0]     pixel_in,
  output logic                                empty,
  input  logic                                pop,
  output logic [tmcx_pkg::PIXEL_BITS-1:0]     pixel_out,
  output logic                                frame_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tmcx_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tmcx_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int ADDR_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int CMD_BITS = 2 * ADDR_BITS + $bits(tmcx_pkg::cmd_info_t);

  logic                 accept;
  logic                 cmdq_full;
  logic                 cmdq_empty;
  logic                 cmd_pop;
  logic                 clearing;
  logic [ADDR_BITS-1:0] front_rd_addr;
  logic [ADDR_BITS-1:0] front_wr_addr;
  tmcx_pkg::cmd_info_t  front_info;
  logic [ADDR_BITS-1:0] cmd_rd_addr;
  logic [ADDR_BITS-1:0] cmd_wr_addr;
  tmcx_pkg::cmd_info_t  cmd_info;
  tmcx_pkg::result_t    result;

  assign full = cmdq_full || clearing;
  assign accept = push && !full;
  assign cfg_ready = 1'b1;
  assign pixel_out = result.pixel;
  assign frame_last = result.last;

  tmcx_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .pixel_in (pixel_in),
    .cfg_write(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rd_addr  (front_rd_addr),
    .wr_addr  (front_wr_addr),
    .info     (front_info)
  );

  tmcx_fifo #(
    .WIDTH(CMD_BITS),
    .DEPTH(tmcx_pkg::QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data({front_rd_addr, front_wr_addr, front_info}),
    .pop      (cmd_pop),
    .pop_data ({cmd_rd_addr, cmd_wr_addr, cmd_info}),
    .empty    (cmdq_empty),
    .full     (cmdq_full),
    .count    ()
  );

  tmcx_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (!cmdq_empty),
    .cmd_rd_addr(cmd_rd_addr),
    .cmd_wr_addr(cmd_wr_addr),
    .cmd_info   (cmd_info),
    .cmd_pop    (cmd_pop),
    .clearing   (clearing),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

FILE: tb/tmcx_checker.sv
// Checker for the mosaic color XOR block: watches the pixel, result and register channels.
// Keeps its own frame store and position counters and compares every popped result.
// Depends on tmcx_pkg for widths, register indexes and the result type.
module tmcx_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                full,
  input  logic [tmcx_pkg::PIXEL_BITS-1:0]     pixel_in,
  input  logic                                empty,
  input  logic                                pop,
  input  logic [tmcx_pkg::PIXEL_BITS-1:0]     pixel_out,
  input  logic                                frame_last,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [tmcx_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tmcx_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  errors,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W = tmcx_pkg::DEFAULT_MAX_WIDTH;
  localparam int unsigned MAX_H = tmcx_pkg::DEFAULT_MAX_HEIGHT;
  localparam int unsigned BANK_WORDS = MAX_W * MAX_H;
  localparam logic [tmcx_pkg::PIXEL_BITS-1:0] TILE_TINT [9] = '{
    32'h0000_0080, 32'h0000_8000, 32'h0080_0000,
    32'h0000_e000, 32'h0080_8000, 32'h0080_0080,
    32'h0080_8080, 32'h0000_8080, 32'h00e0_e000
  };

  tmcx_pkg::result_t mosaic_due [$];
  logic [tmcx_pkg::PIXEL_BITS-1:0] frame_mem [int unsigned];
  logic [tmcx_pkg::CFG_DATA_BITS-1:0] width_reg = 9'd256;
  logic [tmcx_pkg::CFG_DATA_BITS-1:0] height_reg = 9'd256;
  logic bank = 1'b0;
  int unsigned col, row, wr_addr, src_col, src_row;
  logic [1:0] tile_col, tile_row;
  int mismatches = 0;

  function automatic int unsigned clamp_size(logic [tmcx_pkg::CFG_DATA_BITS-1:0] v,
                                             int unsigned ceiling);
    if (v == '0) return 1;
    if (32'(v) > ceiling) return ceiling;
    return 32'(v);
  endfunction

  task automatic restart_frame();
    col = 0;
    row = 0;
    wr_addr = 0;
    src_col = 0;
    src_row = 0;
    tile_col = '0;
    tile_row = '0;
  endtask

  task automatic advance_mod(inout int unsigned rem, inout logic [1:0] quot,
                             input int unsigned n);
    rem += 3;
    repeat (3) begin
      if (rem >= n) begin
        rem -= n;
        quot += 2'd1;
      end
    end
  endtask

  task automatic predict_mosaic(input logic [tmcx_pkg::PIXEL_BITS-1:0] pix,
                                output tmcx_pkg::result_t r);
    int unsigned w, h, raddr, tile, rkey;
    logic rbank, last_col, last_row;
    logic [tmcx_pkg::PIXEL_BITS-1:0] src, tint;
    w = clamp_size(width_reg, MAX_W);
    h = clamp_size(height_reg, MAX_H);
    rbank = ~bank;
    raddr = src_row * w + src_col;
    rkey = (rbank ? BANK_WORDS : 0) + raddr;
    tile = (int'(tile_row) * 3 + int'(tile_col)) & 15;
    last_col = col >= w - 1;
    last_row = row >= h - 1;
    src = '0;
    if (raddr < BANK_WORDS && frame_mem.exists(rkey)) src = frame_mem[rkey];
    if (wr_addr < BANK_WORDS) frame_mem[(bank ? BANK_WORDS : 0) + wr_addr] = pix;
    tint = (tile < 9) ? TILE_TINT[tile] : '0;
    r.pixel = src ^ tint;
    r.last = last_col && last_row;
    if (last_col && last_row) begin
      bank = rbank;
      restart_frame();
    end else if (last_col) begin
      col = 0;
      src_col = 0;
      tile_col = '0;
      row++;
      wr_addr = row * w;
      advance_mod(src_row, tile_row, h);
    end else begin
      col++;
      wr_addr++;
      advance_mod(src_col, tile_col, w);
    end
  endtask

  task automatic report_mismatch(string what, logic [tmcx_pkg::PIXEL_BITS-1:0] want,
                                 logic [tmcx_pkg::PIXEL_BITS-1:0] got);
    mismatches++;
    $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    tmcx_pkg::result_t want;
    tmcx_pkg::result_t fresh;
    if (rst) begin
      mosaic_due.delete();
      frame_mem.delete();
      bank = 1'b0;
      width_reg = 9'd256;
      height_reg = 9'd256;
      restart_frame();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tmcx_pkg::CFG_FRAME_WIDTH: begin
            width_reg = cfg_data;
            restart_frame();
          end
          tmcx_pkg::CFG_FRAME_HEIGHT: begin
            height_reg = cfg_data;
            restart_frame();
          end
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (mosaic_due.size() == 0) begin
          report_mismatch("result with no request waiting", '0, pixel_out);
        end else begin
          want = mosaic_due.pop_front();
          if (pixel_out !== want.pixel) report_mismatch("pixel_out", want.pixel, pixel_out);
          if (frame_last !== want.last) report_mismatch("frame_last", want.last, frame_last);
        end
      end
      if (push && !full) begin
        predict_mosaic(pixel_in, fresh);
        mosaic_due.push_back(fresh);
      end
    end
    pending <= mosaic_due.size();
    errors <= mismatches;
  end

endmodule

FILE: tb/tiled_mosaic_color_xor_tb.sv
// Top of the mosaic color XOR testbench: clock, reset, pixel and register stimulus, verdict.
// Depends on tmcx_pkg, the block tiled_mosaic_color_xor and the checker tmcx_checker.
module tiled_mosaic_color_xor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tmcx_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [tmcx_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [tmcx_pkg::PIXEL_BITS-1:0] pixel_in = '0;
  logic cfg_valid = 1'b0;
  logic [tmcx_pkg::CFG_INDEX_BITS-1:0] cfg_index = tmcx_pkg::CFG_FRAME_WIDTH;
  logic [tmcx_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic full, empty, frame_last, cfg_ready;
  logic [tmcx_pkg::PIXEL_BITS-1:0] pixel_out;
  int mismatches, pending;
  int unsigned cyc = 0;

  tiled_mosaic_color_xor u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .pixel_in(pixel_in),
    .empty(empty), .pop(pop), .pixel_out(pixel_out), .frame_last(frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tmcx_checker u_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .pixel_in(pixel_in),
    .empty(empty), .pop(pop), .pixel_out(pixel_out), .frame_last(frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(mismatches), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;

  function automatic logic calm();
    return (cyc % 3000) < 800;
  endfunction

  always @(posedge clk) pop <= !rst && (calm() || $urandom_range(99) >= 32);

  function automatic int unsigned pixels_per(logic [tmcx_pkg::CFG_DATA_BITS-1:0] raw);
    if (raw == '0) return 1;
    if (raw > 9'd256) return 256;
    return 32'(raw);
  endfunction

  function automatic logic [tmcx_pkg::PIXEL_BITS-1:0] random_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_pixel(input logic [tmcx_pkg::PIXEL_BITS-1:0] v);
    while (!calm() && $urandom_range(99) < 32) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    pixel_in <= v;
    do @(posedge clk); while (full);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_pixel(random_pixel());
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [tmcx_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [tmcx_pkg::CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [tmcx_pkg::CFG_DATA_BITS-1:0] w,
                           input logic [tmcx_pkg::CFG_DATA_BITS-1:0] h,
                           input bit spare);
    logic swap;
    swap = 1'($urandom_range(1));
    write_reg(swap ? tmcx_pkg::CFG_FRAME_HEIGHT : tmcx_pkg::CFG_FRAME_WIDTH, swap ? h : w);
    if (spare) begin
      write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                tmcx_pkg::CFG_DATA_BITS'($urandom()));
    end
    write_reg(swap ? tmcx_pkg::CFG_FRAME_WIDTH : tmcx_pkg::CFG_FRAME_HEIGHT, swap ? w : h);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned sent, area, n;
    logic [tmcx_pkg::CFG_DATA_BITS-1:0] w, h;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_pixel('0);
    send_pixel('1);
    send_pixel(32'ha5a5_a5a5);
    send_pixel(32'h5a5a_5a5a);
    drain();
    configure(9'd3, 9'd3, 1'b1);
    for (int i = 0; i < 9; i++) send_pixel(i == 0 ? '1 : (32'h1 << (i * 4 - 1)) | i);
    drain();
    send_random(9);
    drain();

    configure(9'h1ff, 9'd0, 1'b0);
    send_random(300);
    drain();
    configure(9'd0, 9'd300, 1'b1);
    send_random(100);
    w = 9'd0;
    h = 9'd300;

    sent = 0;
    while (sent < 100) begin
      drain();
      if ($urandom_range(3) != 0) begin
        if ($urandom_range(7) == 0) begin
          w = tmcx_pkg::CFG_DATA_BITS'($urandom_range(257, 511));
          h = tmcx_pkg::CFG_DATA_BITS'($urandom_range(0, 2));
          if ($urandom_range(1)) {w, h} = {h, w};
        end else begin
          w = tmcx_pkg::CFG_DATA_BITS'($urandom_range(0, 9));
          h = tmcx_pkg::CFG_DATA_BITS'($urandom_range(0, 9));
        end
        configure(w, h, $urandom_range(3) == 0);
      end
      area = pixels_per(w) * pixels_per(h);
      n = (area > 64) ? $urandom_range(20, 100)
                      : area * $urandom_range(1, 3) + $urandom_range(0, area - 1);
      send_random(n);
      sent += n;
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
